// ===== hw/rtl/prs_pkg.sv =====
// ----------------------------------------------------------------------------
// prs_pkg
// Shared widths, constants and types of the particle resampler.
// ----------------------------------------------------------------------------
package prs_pkg;

    localparam int PARTICLES     = 64;
    localparam int FRACTION_BITS = 24;

    localparam int WEIGHT_W  = 25;
    localparam int UNIFORM_W = 24;
    localparam int OUT_IDX_W = 6;
    localparam int SUM_W     = 32;
    localparam int IDX_W     = $clog2(PARTICLES);
    localparam int CNT_W     = IDX_W + 1;
    localparam int KEY_W     = (FRACTION_BITS + 1 > UNIFORM_W) ? FRACTION_BITS + 1 : UNIFORM_W;

    localparam int STRIDE     = (1 << FRACTION_BITS) / PARTICLES;
    localparam int STRIDE_MOD = (STRIDE == 0) ? 1 : STRIDE;

    localparam logic METHOD_SYSTEMATIC  = 1'b0;
    localparam logic METHOD_MULTINOMIAL = 1'b1;

    localparam logic KIND_LOAD = 1'b0;
    localparam logic KIND_DRAW = 1'b1;

    typedef logic [IDX_W-1:0]     idx_t;
    typedef logic [CNT_W-1:0]     cnt_t;
    typedef logic [KEY_W-1:0]     key_t;
    typedef logic [SUM_W-1:0]     sum_t;
    typedef logic [SUM_W:0]       sum_ext_t;
    typedef logic [OUT_IDX_W-1:0] out_idx_t;
    typedef logic [UNIFORM_W-1:0] uniform_t;

    typedef struct packed {
        out_idx_t particle_index;
        logic     last_draw;
    } prs_result_t;

    typedef struct packed {
        logic en;
        idx_t addr;
        sum_t data;
    } prs_wr_t;

endpackage

// ===== hw/rtl/prs_if.sv =====
// ----------------------------------------------------------------------------
// prs_if
// Channel interfaces of the particle resampler: input, result, configuration.
// ----------------------------------------------------------------------------
interface prs_in_if;
    logic                           valid;
    logic                           ready;
    logic                           kind;
    logic [prs_pkg::WEIGHT_W-1:0]   weight;
    logic [prs_pkg::UNIFORM_W-1:0]  uniform;

    modport source (output valid, output kind, output weight, output uniform, input ready);
    modport sink   (input valid, input kind, input weight, input uniform, output ready);
endinterface

interface prs_out_if;
    logic                           valid;
    logic                           ready;
    logic [prs_pkg::OUT_IDX_W-1:0]  particle_index;
    logic                           last_draw;

    modport source (output valid, output particle_index, output last_draw, input ready);
    modport sink   (input valid, input particle_index, input last_draw, output ready);
endinterface

interface prs_cfg_if;
    logic valid;
    logic ready;
    logic resample_method;

    modport source (output valid, output resample_method, input ready);
    modport sink   (input valid, input resample_method, output ready);
endinterface

// ===== hw/rtl/prs_store.sv =====
// ----------------------------------------------------------------------------
// prs_store
// Prefix-sum memory: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module prs_store
(
    input  logic              clk,
    input  prs_pkg::prs_wr_t  wr,
    input  prs_pkg::idx_t     rd_addr,
    output prs_pkg::sum_t     rd_data
);

    prs_pkg::sum_t mem [prs_pkg::PARTICLES];
    prs_pkg::sum_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr] <= wr.data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== hw/rtl/prs_seq.sv =====
// ----------------------------------------------------------------------------
// prs_seq
// Sequencer of the resampler: prefix accumulation on loads, and a cursor scan
// or lower-bound search over the store on draws, through one shared compare.
// ----------------------------------------------------------------------------
module prs_seq
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic                          kind,
    input  logic [prs_pkg::WEIGHT_W-1:0]  weight,
    input  prs_pkg::uniform_t             uniform,
    input  logic                          method,
    output logic                          idle,
    output logic                          res_valid,
    output prs_pkg::prs_result_t          res,
    input  logic                          res_take,
    output prs_pkg::prs_wr_t              wr,
    output prs_pkg::idx_t                 rd_addr,
    input  prs_pkg::sum_t                 rd_data
);

    typedef enum logic [1:0] {S_IDLE, S_READ, S_CMP, S_DONE} state_t;

    localparam prs_pkg::idx_t LAST_IDX  = prs_pkg::idx_t'(prs_pkg::PARTICLES - 1);
    localparam prs_pkg::cnt_t CNT_TOTAL = prs_pkg::cnt_t'(prs_pkg::PARTICLES);

    state_t            state_reg,    state_next;
    prs_pkg::idx_t     load_cnt_reg, load_cnt_next;
    prs_pkg::idx_t     draw_cnt_reg, draw_cnt_next;
    prs_pkg::idx_t     cursor_reg,   cursor_next;
    prs_pkg::key_t     offset_reg,   offset_next;
    prs_pkg::sum_t     last_sum_reg, last_sum_next;
    prs_pkg::key_t     key_reg,      key_next;
    prs_pkg::cnt_t     lo_reg,       lo_next;
    prs_pkg::cnt_t     hi_reg,       hi_next;
    prs_pkg::idx_t     mid_reg,      mid_next;
    logic              mode_reg,     mode_next;
    prs_pkg::idx_t     idx_reg,      idx_next;
    logic              last_reg,     last_next;

    prs_pkg::sum_ext_t sum_ext;
    prs_pkg::sum_t     sum_sat;
    prs_pkg::key_t     offset_new;
    prs_pkg::cnt_t     mid_calc;
    prs_pkg::cnt_t     lo_step;
    prs_pkg::cnt_t     hi_step;
    logic              key_gt;

    assign sum_ext  = {1'b0, last_sum_reg} + prs_pkg::sum_ext_t'(weight);
    assign sum_sat  = sum_ext[prs_pkg::SUM_W] ? '1 : sum_ext[prs_pkg::SUM_W-1:0];
    assign mid_calc = lo_reg + ((hi_reg - lo_reg) >> 1);
    assign key_gt   = prs_pkg::sum_t'(key_reg) > rd_data;
    assign lo_step  = key_gt ? prs_pkg::cnt_t'(mid_reg) + prs_pkg::cnt_t'(1) : lo_reg;
    assign hi_step  = key_gt ? hi_reg : prs_pkg::cnt_t'(mid_reg);

    always_comb
    begin
        if (prs_pkg::STRIDE == 0)
        begin
            offset_new = '0;
        end
        else
        begin
            offset_new = prs_pkg::key_t'(uniform % prs_pkg::STRIDE_MOD);
        end
    end

    assign idle      = (state_reg == S_IDLE);
    assign res_valid = (state_reg == S_DONE);
    assign res.particle_index = prs_pkg::out_idx_t'(idx_reg);
    assign res.last_draw      = last_reg;

    assign wr.en   = start && idle && (kind == prs_pkg::KIND_LOAD);
    assign wr.addr = load_cnt_reg;
    assign wr.data = sum_sat;

    assign rd_addr = (mode_reg == prs_pkg::METHOD_MULTINOMIAL)
                     ? prs_pkg::idx_t'(mid_calc) : cursor_reg;

    always_comb
    begin
        state_next    = state_reg;
        load_cnt_next = load_cnt_reg;
        draw_cnt_next = draw_cnt_reg;
        cursor_next   = cursor_reg;
        offset_next   = offset_reg;
        last_sum_next = last_sum_reg;
        key_next      = key_reg;
        lo_next       = lo_reg;
        hi_next       = hi_reg;
        mid_next      = mid_reg;
        mode_next     = mode_reg;
        idx_next      = idx_reg;
        last_next     = last_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (start && kind == prs_pkg::KIND_LOAD)
                begin
                    if (load_cnt_reg == LAST_IDX)
                    begin
                        load_cnt_next = '0;
                        last_sum_next = '0;
                    end
                    else
                    begin
                        load_cnt_next = load_cnt_reg + prs_pkg::idx_t'(1);
                        last_sum_next = sum_sat;
                    end
                end
                else if (start)
                begin
                    mode_next     = method;
                    last_next     = (draw_cnt_reg == LAST_IDX);
                    draw_cnt_next = (draw_cnt_reg == LAST_IDX) ? '0
                                    : draw_cnt_reg + prs_pkg::idx_t'(1);
                    lo_next       = '0;
                    hi_next       = CNT_TOTAL;
                    if (method == prs_pkg::METHOD_MULTINOMIAL)
                    begin
                        key_next = prs_pkg::key_t'(uniform);
                    end
                    else if (draw_cnt_reg == '0)
                    begin
                        offset_next = offset_new;
                        cursor_next = '0;
                        key_next    = offset_new;
                    end
                    else
                    begin
                        key_next = offset_reg + prs_pkg::key_t'(draw_cnt_reg)
                                   * prs_pkg::key_t'(prs_pkg::STRIDE);
                    end
                    state_next = S_READ;
                end
            end
            S_READ:
            begin
                mid_next   = prs_pkg::idx_t'(mid_calc);
                state_next = S_CMP;
            end
            S_CMP:
            begin
                if (mode_reg == prs_pkg::METHOD_MULTINOMIAL)
                begin
                    lo_next = lo_step;
                    hi_next = hi_step;
                    if (lo_step < hi_step)
                    begin
                        state_next = S_READ;
                    end
                    else
                    begin
                        idx_next   = (lo_step >= CNT_TOTAL) ? LAST_IDX
                                     : prs_pkg::idx_t'(lo_step);
                        state_next = S_DONE;
                    end
                end
                else if (key_gt && cursor_reg != LAST_IDX)
                begin
                    cursor_next = cursor_reg + prs_pkg::idx_t'(1);
                    state_next  = S_READ;
                end
                else
                begin
                    idx_next   = cursor_reg;
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (res_take)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            load_cnt_reg <= '0;
            draw_cnt_reg <= '0;
            cursor_reg   <= '0;
            offset_reg   <= '0;
            last_sum_reg <= '0;
            mode_reg     <= prs_pkg::METHOD_SYSTEMATIC;
            key_reg      <= '0;
            lo_reg       <= '0;
            hi_reg       <= '0;
            mid_reg      <= '0;
            idx_reg      <= '0;
            last_reg     <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            load_cnt_reg <= load_cnt_next;
            draw_cnt_reg <= draw_cnt_next;
            cursor_reg   <= cursor_next;
            offset_reg   <= offset_next;
            last_sum_reg <= last_sum_next;
            mode_reg     <= mode_next;
            key_reg      <= key_next;
            lo_reg       <= lo_next;
            hi_reg       <= hi_next;
            mid_reg      <= mid_next;
            idx_reg      <= idx_next;
            last_reg     <= last_next;
        end
    end

endmodule

// ===== hw/rtl/particle_resampler_unit.sv =====
// ----------------------------------------------------------------------------
// particle_resampler_unit
// Particle filter resampler: prefix-sum store with systematic and
// multinomial index selection.
// ----------------------------------------------------------------------------
// Channels: in_ch takes beats of kind, weight and uniform; a load beat adds
// one weight to the prefix store, a draw beat yields one beat on out_ch with
// the chosen particle_index and last_draw on the final draw of a set. cfg
// writes resample_method (0 systematic, 1 multinomial) and is always ready;
// write it only while the block is idle.
// Sequencing: a load writes the store from the idle state. A systematic draw
// reads and compares entries from the cursor on until the key no longer
// exceeds one or the last entry is reached; a multinomial draw reads and
// compares one entry per binary-search probe (at most 7 for 64 particles).
// Both use the single read port of the prefix store and one shared comparator,
// one probe at a time. in_ch.ready is high only while the sequencer is idle.
// Results sit in an output register, so the next beat is taken while a
// result waits; a stalled receiver holds the result and blocks only the
// completion of the following draw.
// Reset clears the counters, cursor, offset and method; the prefix store is
// undefined until loaded.
// ----------------------------------------------------------------------------
module particle_resampler_unit
(
    input  logic       clk,
    input  logic       rst_n,
    prs_in_if.sink     in_ch,
    prs_out_if.source  out_ch,
    prs_cfg_if.sink    cfg
);

    logic                  method_reg;
    logic                  out_valid_reg;
    prs_pkg::prs_result_t  out_data_reg;

    logic                  seq_idle;
    logic                  res_valid;
    prs_pkg::prs_result_t  res;
    logic                  res_take;
    prs_pkg::prs_wr_t      wr;
    prs_pkg::idx_t         rd_addr;
    prs_pkg::sum_t         rd_data;

    assign in_ch.ready = seq_idle;
    assign cfg.ready   = 1'b1;
    assign res_take    = !out_valid_reg || out_ch.ready;

    assign out_ch.valid          = out_valid_reg;
    assign out_ch.particle_index = out_data_reg.particle_index;
    assign out_ch.last_draw      = out_data_reg.last_draw;

    prs_seq u_seq
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (in_ch.valid && seq_idle),
        .kind      (in_ch.kind),
        .weight    (in_ch.weight),
        .uniform   (in_ch.uniform),
        .method    (method_reg),
        .idle      (seq_idle),
        .res_valid (res_valid),
        .res       (res),
        .res_take  (res_take),
        .wr        (wr),
        .rd_addr   (rd_addr),
        .rd_data   (rd_data)
    );

    prs_store u_store
    (
        .clk     (clk),
        .wr      (wr),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            method_reg    <= prs_pkg::METHOD_SYSTEMATIC;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg.valid)
            begin
                method_reg <= cfg.resample_method;
            end
            if (res_valid && res_take)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ch.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // hold the result until the receiver takes the beat
    always_ff @(posedge clk)
    begin
        if (res_valid && res_take)
        begin
            out_data_reg <= res;
        end
    end

endmodule
